### sv/rgb_to_hsl_converter_assert.svh
// Assertion macros for the rgb_to_hsl_converter checker.
// Both expect clk and rst_n in the enclosing scope.
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH

// same-cycle implication
`define RHC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhc assertion failed");

// next-cycle implication
`define RHC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhc assertion failed");

`endif

### sv/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

    // quotient bits of both dividers; saturation can reach 65536 before clamping
    localparam int SAT_QUO_W = 17;
    localparam int SAT_W     = 16;
    localparam logic [SAT_W-1:0] SAT_MAX = '1;

    localparam int HUE_STEP_DEG    = 60;
    localparam int GREEN_BASE_DEG  = 120;
    localparam int BLUE_BASE_DEG   = 240;
    localparam int FULL_CIRCLE_DEG = 360;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } hue_sector_t;

    typedef struct packed {
        hue_sector_t sector;
        logic        neg;     // offset is subtracted from the sector base
        logic        gray;    // zero chroma
    } hue_ctl_t;

endpackage

### sv/rhc_stream_if.sv
`timescale 1ns / 1ps

interface rhc_pix_if #(
    parameter int COMPONENT_BITS = 8
);
    logic                      valid;
    logic                      ready;
    logic [COMPONENT_BITS-1:0] red;
    logic [COMPONENT_BITS-1:0] green;
    logic [COMPONENT_BITS-1:0] blue;
    logic [COMPONENT_BITS-1:0] alpha_in;

    modport source (output valid, red, green, blue, alpha_in, input ready);
    modport sink   (input valid, red, green, blue, alpha_in, output ready);
endinterface

interface rhc_hsl_if import rhc_pkg::*; #(
    parameter int COMPONENT_BITS    = 8,
    parameter int HUE_FRACTION_BITS = 6
);
    logic                           valid;
    logic                           ready;
    logic [9+HUE_FRACTION_BITS-1:0] hue;
    logic [SAT_W-1:0]               saturation;
    logic [COMPONENT_BITS:0]        lightness_sum;
    logic [COMPONENT_BITS-1:0]      alpha_out;

    modport source (output valid, hue, saturation, lightness_sum, alpha_out, input ready);
    modport sink   (input valid, hue, saturation, lightness_sum, alpha_out, output ready);
endinterface

### sv/rhc_prep.sv
`timescale 1ns / 1ps

// Two stages: max/min/sector pick, then divider operands.
module rhc_prep import rhc_pkg::*; #(
    parameter int COMPONENT_BITS    = 8,
    parameter int HUE_FRACTION_BITS = 6,
    parameter int HNUM_W            = 22,
    parameter int SNUM_W            = 25,
    parameter int DEN_W             = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        in_valid,
    input  logic [COMPONENT_BITS-1:0]   red,
    input  logic [COMPONENT_BITS-1:0]   green,
    input  logic [COMPONENT_BITS-1:0]   blue,
    input  logic [COMPONENT_BITS-1:0]   alpha_in,
    output logic                        out_valid,
    output hue_ctl_t                    out_ctl,
    output logic [2*COMPONENT_BITS:0]   out_side,
    output logic [HNUM_W-1:0]           h_num,
    output logic [DEN_W-1:0]            h_den,
    output logic [SNUM_W-1:0]           s_num,
    output logic [DEN_W-1:0]            s_den
);
    localparam int CB = COMPONENT_BITS;
    localparam int HF = HUE_FRACTION_BITS;
    localparam logic [CB-1:0] FULL = '1;

    // stage 1
    hue_ctl_t      ctl1;
    logic [CB-1:0] mx, mn, pos_c, neg_c, diff1, chroma1;
    logic [CB:0]   sum1;

    always_comb
    begin
        if ((red >= green) && (red >= blue))
        begin
            ctl1.sector = SECT_RED;
            mx          = red;
            mn          = (green < blue) ? green : blue;
            pos_c       = green;
            neg_c       = blue;
        end
        else if (green >= blue)
        begin
            ctl1.sector = SECT_GREEN;
            mx          = green;
            mn          = (red < blue) ? red : blue;
            pos_c       = blue;
            neg_c       = red;
        end
        else
        begin
            ctl1.sector = SECT_BLUE;
            mx          = blue;
            mn          = (red < green) ? red : green;
            pos_c       = red;
            neg_c       = green;
        end
        ctl1.neg  = pos_c < neg_c;
        diff1     = ctl1.neg ? (neg_c - pos_c) : (pos_c - neg_c);
        chroma1   = mx - mn;
        sum1      = {1'b0, mx} + {1'b0, mn};
        ctl1.gray = (chroma1 == '0);
    end

    logic          v1_reg;
    hue_ctl_t      ctl1_reg;
    logic [CB-1:0] diff1_reg, chroma1_reg, alpha1_reg;
    logic [CB:0]   sum1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl1_reg    <= ctl1;
            diff1_reg   <= diff1;
            chroma1_reg <= chroma1;
            sum1_reg    <= sum1;
            alpha1_reg  <= alpha_in;
        end
    end

    // stage 2: hue numerator 2*60*2^HF*diff + c (minus one when subtracting)
    // so that one floor divide by 2c gives the rounded offset either way
    logic [HNUM_W-1:0] hq2, h_num2;
    logic [CB-1:0]     dsat;
    logic [SNUM_W-1:0] s_num2;

    always_comb
    begin
        hq2    = (HNUM_W'(diff1_reg) * HNUM_W'(HUE_STEP_DEG)) << (HF + 1);
        h_num2 = hq2 + HNUM_W'(chroma1_reg) - HNUM_W'(ctl1_reg.neg);
        if (sum1_reg > {1'b0, FULL})
        begin
            dsat = CB'({FULL, 1'b0} - sum1_reg);
        end
        else
        begin
            dsat = sum1_reg[CB-1:0];
        end
        s_num2 = {chroma1_reg, SAT_QUO_W'(0)} + SNUM_W'(dsat);
    end

    logic              v2_reg;
    hue_ctl_t          ctl2_reg;
    logic [2*CB:0]     side2_reg;
    logic [HNUM_W-1:0] h_num_reg;
    logic [DEN_W-1:0]  h_den_reg, s_den_reg;
    logic [SNUM_W-1:0] s_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctl2_reg  <= ctl1_reg;
            side2_reg <= {sum1_reg, alpha1_reg};
            h_num_reg <= h_num2;
            h_den_reg <= DEN_W'({chroma1_reg, 1'b0});
            s_num_reg <= s_num2;
            s_den_reg <= DEN_W'({dsat, 1'b0});
        end
    end

    assign out_valid = v2_reg;
    assign out_ctl   = ctl2_reg;
    assign out_side  = side2_reg;
    assign h_num     = h_num_reg;
    assign h_den     = h_den_reg;
    assign s_num     = s_num_reg;
    assign s_den     = s_den_reg;
endmodule

### sv/rhc_div_pipe.sv
`timescale 1ns / 1ps

// Two restoring dividers side by side, one quotient bit per stage.
// Each stage holds the partial remainder and a word that shifts numerator
// bits out of the top while quotient bits enter at the bottom.
module rhc_div_pipe import rhc_pkg::*; #(
    parameter int HNUM_W = 22,
    parameter int SNUM_W = 25,
    parameter int DEN_W  = 9,
    parameter int SIDE_W = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  hue_ctl_t             in_ctl,
    input  logic [SIDE_W-1:0]    in_side,
    input  logic [HNUM_W-1:0]    h_num,
    input  logic [DEN_W-1:0]     h_den,
    input  logic [SNUM_W-1:0]    s_num,
    input  logic [DEN_W-1:0]     s_den,
    output logic                 out_valid,
    output hue_ctl_t             out_ctl,
    output logic [SIDE_W-1:0]    out_side,
    output logic [SAT_QUO_W-1:0] h_quo,
    output logic [SAT_QUO_W-1:0] s_quo
);
    localparam int QW = SAT_QUO_W;
    localparam int HX = (HNUM_W > QW) ? HNUM_W : QW + 1;
    localparam int SX = (SNUM_W > QW) ? SNUM_W : QW + 1;

    // the quotient fits in QW bits, so the bits above QW are below the divisor
    logic [HX-1:0] h_ext;
    logic [SX-1:0] s_ext;
    assign h_ext = HX'(h_num);
    assign s_ext = SX'(s_num);

    logic              valid_reg [0:QW-1];
    hue_ctl_t          ctl_reg   [0:QW-1];
    logic [SIDE_W-1:0] side_reg  [0:QW-1];
    logic [QW-1:0]     h_nq_reg  [0:QW-1];
    logic [QW-1:0]     s_nq_reg  [0:QW-1];
    logic [DEN_W-1:0]  h_rem_reg [0:QW-2];
    logic [DEN_W-1:0]  s_rem_reg [0:QW-2];
    logic [DEN_W-1:0]  h_den_reg [0:QW-2];
    logic [DEN_W-1:0]  s_den_reg [0:QW-2];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic              vi;
        hue_ctl_t          ci;
        logic [SIDE_W-1:0] si;
        logic [DEN_W-1:0]  hr, hd, sr, sd, hr_n, sr_n;
        logic [QW-1:0]     hq, sq;
        logic [DEN_W:0]    h_trial, s_trial;
        logic              h_bit, s_bit;

        if (i == 0)
        begin : g_first
            assign vi = in_valid;
            assign ci = in_ctl;
            assign si = in_side;
            assign hr = DEN_W'(h_ext >> QW);
            assign hq = h_ext[QW-1:0];
            assign hd = h_den;
            assign sr = DEN_W'(s_ext >> QW);
            assign sq = s_ext[QW-1:0];
            assign sd = s_den;
        end
        else
        begin : g_next
            assign vi = valid_reg[i-1];
            assign ci = ctl_reg[i-1];
            assign si = side_reg[i-1];
            assign hr = h_rem_reg[i-1];
            assign hq = h_nq_reg[i-1];
            assign hd = h_den_reg[i-1];
            assign sr = s_rem_reg[i-1];
            assign sq = s_nq_reg[i-1];
            assign sd = s_den_reg[i-1];
        end

        always_comb
        begin
            h_trial = {hr, hq[QW-1]};
            h_bit   = h_trial >= {1'b0, hd};
            hr_n    = h_bit ? DEN_W'(h_trial - {1'b0, hd}) : h_trial[DEN_W-1:0];
            s_trial = {sr, sq[QW-1]};
            s_bit   = s_trial >= {1'b0, sd};
            sr_n    = s_bit ? DEN_W'(s_trial - {1'b0, sd}) : s_trial[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                ctl_reg[i]  <= ci;
                side_reg[i] <= si;
                h_nq_reg[i] <= {hq[QW-2:0], h_bit};
                s_nq_reg[i] <= {sq[QW-2:0], s_bit};
            end
        end

        if (i < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    h_rem_reg[i] <= hr_n;
                    s_rem_reg[i] <= sr_n;
                    h_den_reg[i] <= hd;
                    s_den_reg[i] <= sd;
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_ctl   = ctl_reg[QW-1];
    assign out_side  = side_reg[QW-1];
    assign h_quo     = h_nq_reg[QW-1];
    assign s_quo     = s_nq_reg[QW-1];
endmodule

### sv/rhc_out.sv
`timescale 1ns / 1ps

// Hue assembly, saturation clamp, output register and skid register.
module rhc_out import rhc_pkg::*; #(
    parameter int COMPONENT_BITS    = 8,
    parameter int HUE_FRACTION_BITS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          advance,
    input  logic                          in_valid,
    input  hue_ctl_t                      in_ctl,
    input  logic [2*COMPONENT_BITS:0]     in_side,
    input  logic [SAT_QUO_W-1:0]          h_quo,
    input  logic [SAT_QUO_W-1:0]          s_quo,
    rhc_hsl_if.source                     hsla
);
    localparam int CB    = COMPONENT_BITS;
    localparam int HF    = HUE_FRACTION_BITS;
    localparam int HUE_W = 9 + HF;
    localparam logic [HUE_W-1:0] HUE_FULL  = HUE_W'(FULL_CIRCLE_DEG * (2 ** HF));
    localparam logic [HUE_W-1:0] HUE_GREEN = HUE_W'(GREEN_BASE_DEG * (2 ** HF));
    localparam logic [HUE_W-1:0] HUE_BLUE  = HUE_W'(BLUE_BASE_DEG * (2 ** HF));

    logic [HUE_W-1:0] hq, hue_raw, hue_fin;
    logic [SAT_W-1:0] sat_fin;

    always_comb
    begin
        hq = HUE_W'(h_quo);
        case (in_ctl.sector)
            SECT_RED:   hue_raw = in_ctl.neg ? (HUE_FULL - hq) : hq;
            SECT_GREEN: hue_raw = in_ctl.neg ? (HUE_GREEN - hq) : (HUE_GREEN + hq);
            SECT_BLUE:  hue_raw = in_ctl.neg ? (HUE_BLUE - hq) : (HUE_BLUE + hq);
            default:    hue_raw = '0;
        endcase
        // a subtracted red-sector offset that rounds to zero lands on a full turn
        hue_fin = (hue_raw >= HUE_FULL) ? (hue_raw - HUE_FULL) : hue_raw;
        if (in_ctl.gray)
        begin
            hue_fin = '0;
        end

        if (in_ctl.gray)
        begin
            sat_fin = '0;
        end
        else if (s_quo[SAT_QUO_W-1])
        begin
            sat_fin = SAT_MAX;
        end
        else
        begin
            sat_fin = s_quo[SAT_W-1:0];
        end
    end

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [HUE_W-1:0] hue_reg, skid_hue_reg;
    logic [SAT_W-1:0] sat_reg, skid_sat_reg;
    logic [CB:0]      sum_reg, skid_sum_reg;
    logic [CB-1:0]    alpha_reg, skid_alpha_reg;
    logic             take, load_new, load_from_skid, load_skid;

    always_comb
    begin
        take            = out_valid_reg && hsla.ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_new        = 1'b0;
        load_from_skid  = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                load_from_skid  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || take)
            begin
                load_new       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_new)
        begin
            hue_reg   <= hue_fin;
            sat_reg   <= sat_fin;
            sum_reg   <= in_side[2*CB:CB];
            alpha_reg <= in_side[CB-1:0];
        end
        else if (load_from_skid)
        begin
            hue_reg   <= skid_hue_reg;
            sat_reg   <= skid_sat_reg;
            sum_reg   <= skid_sum_reg;
            alpha_reg <= skid_alpha_reg;
        end
        if (load_skid)
        begin
            skid_hue_reg   <= hue_fin;
            skid_sat_reg   <= sat_fin;
            skid_sum_reg   <= in_side[2*CB:CB];
            skid_alpha_reg <= in_side[CB-1:0];
        end
    end

    assign advance            = !skid_valid_reg;
    assign hsla.valid         = out_valid_reg;
    assign hsla.hue           = hue_reg;
    assign hsla.saturation    = sat_reg;
    assign hsla.lightness_sum = sum_reg;
    assign hsla.alpha_out     = alpha_reg;
endmodule

### sv/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps

// Channel  Dir  Beat payload                                   Handshake
// -------  ---  ---------------------------------------------  -----------
// rgba     in   red, green, blue, alpha_in                     valid/ready
// hsla     out  hue, saturation, lightness_sum, alpha_out      valid/ready
//
// Throughput: one pixel per clock while the skid is empty. Between accepted
// beat and output valid lie 2 operand stages, 17 divider stages and 1 output
// register; the divider length is the 17 quotient bits that saturation needs.
// Reset: rst_n async, clears every valid bit; data registers are not reset.
// Stalls: a skid register behind the output register catches one beat; the
// whole pipeline freezes only while the skid is full, so rgba.ready is a flop.
module rgb_to_hsl_converter import rhc_pkg::*; #(
    parameter int COMPONENT_BITS    = 8,
    parameter int HUE_FRACTION_BITS = 6
) (
    input  logic      clk,
    input  logic      rst_n,
    rhc_pix_if.sink   rgba,
    rhc_hsl_if.source hsla
);
    localparam int CB     = COMPONENT_BITS;
    localparam int HF     = HUE_FRACTION_BITS;
    // 2 * 60 * 2^HF * diff + c
    localparam int HNUM_W = CB + HF + 8;
    // c * 2^17 + d
    localparam int SNUM_W = CB + SAT_QUO_W;
    // 2c and 2d
    localparam int DEN_W  = CB + 1;
    // lightness sum and alpha ride along
    localparam int SIDE_W = 2 * CB + 1;

    logic              advance;

    logic              pre_valid;
    hue_ctl_t          pre_ctl;
    logic [SIDE_W-1:0] pre_side;
    logic [HNUM_W-1:0] pre_h_num;
    logic [DEN_W-1:0]  pre_h_den;
    logic [SNUM_W-1:0] pre_s_num;
    logic [DEN_W-1:0]  pre_s_den;

    logic                 div_valid;
    hue_ctl_t             div_ctl;
    logic [SIDE_W-1:0]    div_side;
    logic [SAT_QUO_W-1:0] div_h_quo;
    logic [SAT_QUO_W-1:0] div_s_quo;

    // all stages move together; a beat is taken whenever the skid is empty
    assign rgba.ready = advance;

    rhc_prep #(
        .COMPONENT_BITS    (CB),
        .HUE_FRACTION_BITS (HF),
        .HNUM_W            (HNUM_W),
        .SNUM_W            (SNUM_W),
        .DEN_W             (DEN_W)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (rgba.valid),
        .red       (rgba.red),
        .green     (rgba.green),
        .blue      (rgba.blue),
        .alpha_in  (rgba.alpha_in),
        .out_valid (pre_valid),
        .out_ctl   (pre_ctl),
        .out_side  (pre_side),
        .h_num     (pre_h_num),
        .h_den     (pre_h_den),
        .s_num     (pre_s_num),
        .s_den     (pre_s_den)
    );

    rhc_div_pipe #(
        .HNUM_W (HNUM_W),
        .SNUM_W (SNUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (pre_valid),
        .in_ctl    (pre_ctl),
        .in_side   (pre_side),
        .h_num     (pre_h_num),
        .h_den     (pre_h_den),
        .s_num     (pre_s_num),
        .s_den     (pre_s_den),
        .out_valid (div_valid),
        .out_ctl   (div_ctl),
        .out_side  (div_side),
        .h_quo     (div_h_quo),
        .s_quo     (div_s_quo)
    );

    // gray pixels are forced to zero hue and saturation here, which also
    // covers the divide-by-zero lanes
    rhc_out #(
        .COMPONENT_BITS    (CB),
        .HUE_FRACTION_BITS (HF)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (div_valid),
        .in_ctl   (div_ctl),
        .in_side  (div_side),
        .h_quo    (div_h_quo),
        .s_quo    (div_s_quo),
        .hsla     (hsla)
    );
endmodule

### sv/rhc_checker.sv
`timescale 1ns / 1ps

`include "rgb_to_hsl_converter_assert.svh"

module rhc_checker import rhc_pkg::*; #(
    parameter int COMPONENT_BITS    = 8,
    parameter int HUE_FRACTION_BITS = 6
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [9+HUE_FRACTION_BITS-1:0] hue,
    input logic [SAT_W-1:0]               saturation,
    input logic [COMPONENT_BITS:0]        lightness_sum
);
    localparam int HUE_W = 9 + HUE_FRACTION_BITS;
    localparam logic [HUE_W-1:0] HUE_LIMIT =
        HUE_W'(FULL_CIRCLE_DEG * (2 ** HUE_FRACTION_BITS));
    localparam logic [COMPONENT_BITS:0] SUM_TOP = {{COMPONENT_BITS{1'b1}}, 1'b0};

    `RHC_ASSERT_IMP(a_hue_range, out_valid, hue < HUE_LIMIT)

    // black and white have no chroma
    `RHC_ASSERT_IMP(a_extreme_gray, out_valid && (lightness_sum == '0 || lightness_sum == SUM_TOP), hue == '0 && saturation == '0)

    `RHC_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(hue) && $stable(saturation) && $stable(lightness_sum))

    // input backpressure only follows an output stall
    `RHC_ASSERT_IMP(a_ready_cause, !in_ready, $past(out_valid && !out_ready))
endmodule

bind rgb_to_hsl_converter rhc_checker #(
    .COMPONENT_BITS    (COMPONENT_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
) u_rhc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (rgba.ready),
    .out_valid     (hsla.valid),
    .out_ready     (hsla.ready),
    .hue           (hsla.hue),
    .saturation    (hsla.saturation),
    .lightness_sum (hsla.lightness_sum)
);
